/* hw/rtl/fxalu_pkg.sv */
package fxalu_pkg;

  localparam int DataW = 64;
  localparam int CfgW  = 6;
  localparam int ShW   = 7;
  localparam int IdxW  = 2;

  typedef enum logic [1:0] {
    MODE_MUL  = 2'd0,
    MODE_SAT  = 2'd1,
    MODE_CONV = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [IdxW-1:0] {
    REG_INT_BITS   = 2'd0,
    REG_FRAC_BITS  = 2'd1,
    REG_TINT_BITS  = 2'd2,
    REG_TFRAC_BITS = 2'd3
  } reg_idx_t;

  // Per-beat control carried down the chain with the data.
  typedef struct packed {
    logic             vld;
    mode_t            mode;
    logic             neg;
    logic [ShW-1:0]   w;
    logic [CfgW-1:0]  f;
  } ctl_t;

  // Effective format width: clamp to 1..64.
  function automatic logic [ShW-1:0] fmt_width(input logic [CfgW-1:0] ib,
                                               input logic [CfgW-1:0] fb);
    logic [ShW-1:0] s;
    s = {1'b0, ib} + {1'b0, fb};
    if (s == '0) s = ShW'(1);
    if (s > ShW'(64)) s = ShW'(64);
    return s;
  endfunction

  function automatic logic [DataW-1:0] wmask(input logic [ShW-1:0] w);
    logic [DataW-1:0] m;
    if (w >= ShW'(64)) m = '1;
    else m = (DataW'(1) << w[5:0]) - DataW'(1);
    return m;
  endfunction

  function automatic logic [DataW-1:0] sext(input logic [DataW-1:0] v,
                                            input logic [ShW-1:0] w);
    logic [DataW-1:0] m;
    logic [DataW-1:0] r;
    if (w >= ShW'(64)) begin
      r = v;
    end else begin
      m = DataW'(1) << (w[5:0] - 6'd1);
      r = ((v & wmask(w)) ^ m) - m;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/fxalu_front_cell.sv */
// First cell: decode, take magnitudes, form 32x32 partial products,
// compute saturate and convert results.
module fxalu_front_cell
  import fxalu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_vld,
  input  mode_t                in_mode,
  input  logic [DataW-1:0]     a,
  input  logic [DataW-1:0]     b,
  input  logic [CfgW-1:0]      int_bits,
  input  logic [CfgW-1:0]      frac_bits,
  input  logic [CfgW-1:0]      tint_bits,
  input  logic [CfgW-1:0]      tfrac_bits,
  output ctl_t                 ctl,
  output logic [DataW-1:0]     pp_ll,
  output logic [DataW-1:0]     pp_lh,
  output logic [DataW-1:0]     pp_hl,
  output logic [DataW-1:0]     pp_hh,
  output logic [DataW-1:0]     alt
);

  logic [ShW-1:0]   w, tw;
  logic [DataW-1:0] ma, mb, maxv, minv, fm, tfm, ip, fp, packed_v, alt_next;
  logic             na, nb;

  always_comb begin
    w    = fmt_width(int_bits, frac_bits);
    tw   = fmt_width(tint_bits, tfrac_bits);
    na   = a[DataW-1];
    nb   = b[DataW-1];
    ma   = (na ? -a : a) & wmask(w);
    mb   = (nb ? -b : b) & wmask(w);
    maxv = wmask(w) >> 1;
    minv = ~maxv;
    fm   = wmask({1'b0, frac_bits});
    tfm  = wmask({1'b0, tfrac_bits});
    ip   = (a & wmask(w) & ~fm) >> frac_bits;
    fp   = a & fm;
    if (tfrac_bits > frac_bits) fp = fp << (tfrac_bits - frac_bits);
    else fp = fp >> (frac_bits - tfrac_bits);
    packed_v = (fp & tfm) | ((ip << tfrac_bits) & wmask(tw) & ~tfm);
    case (in_mode)
      MODE_SAT: begin
        if ($signed(a) > $signed(maxv)) alt_next = maxv;
        else if ($signed(a) < $signed(minv)) alt_next = minv;
        else alt_next = a;
      end
      MODE_CONV: alt_next = sext(packed_v, tw);
      default:   alt_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.vld <= 1'b0;
    end else if (adv) begin
      ctl.vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl.mode <= in_mode;
      ctl.neg  <= na ^ nb;
      ctl.w    <= w;
      ctl.f    <= frac_bits;
      pp_ll    <= DataW'(ma[31:0]) * DataW'(mb[31:0]);
      pp_lh    <= DataW'(ma[31:0]) * DataW'(mb[63:32]);
      pp_hl    <= DataW'(ma[63:32]) * DataW'(mb[31:0]);
      pp_hh    <= DataW'(ma[63:32]) * DataW'(mb[63:32]);
      alt      <= alt_next;
    end
  end

endmodule

/* hw/rtl/fxalu_sum_cell.sv */
// Second cell: fold partial products into the 128-bit product.
module fxalu_sum_cell
  import fxalu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  ctl_t                 ctl_in,
  input  logic [DataW-1:0]     pp_ll,
  input  logic [DataW-1:0]     pp_lh,
  input  logic [DataW-1:0]     pp_hl,
  input  logic [DataW-1:0]     pp_hh,
  input  logic [DataW-1:0]     alt_in,
  output ctl_t                 ctl,
  output logic [2*DataW-1:0]   prod,
  output logic [DataW-1:0]     alt
);

  logic [2*DataW-1:0] prod_next;

  assign prod_next = {pp_hh, pp_ll} + ({64'd0, pp_lh} << 32) + ({64'd0, pp_hl} << 32);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.vld <= 1'b0;
    end else if (adv) begin
      ctl.vld <= ctl_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl.mode <= ctl_in.mode;
      ctl.neg  <= ctl_in.neg;
      ctl.w    <= ctl_in.w;
      ctl.f    <= ctl_in.f;
      prod     <= prod_next;
      alt      <= alt_in;
    end
  end

endmodule

/* hw/rtl/fxalu_out_cell.sv */
// Last cell: shift, wrap, sign-extend, negate and select the result.
module fxalu_out_cell
  import fxalu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  ctl_t                 ctl_in,
  input  logic [2*DataW-1:0]   prod,
  input  logic [DataW-1:0]     alt_in,
  output logic                 vld,
  output logic [DataW-1:0]     res
);

  logic [2*DataW-1:0] sh;
  logic [DataW-1:0]   r, res_next;

  always_comb begin
    sh = prod >> ctl_in.f;
    r  = sext(sh[DataW-1:0], ctl_in.w);
    if (ctl_in.neg) r = -r;
    if (ctl_in.mode == MODE_MUL) res_next = r;
    else res_next = alt_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv) begin
      vld <= ctl_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= res_next;
    end
  end

endmodule

/* hw/rtl/configurable_fixed_point_alu.sv */
// Channel | Signals                              | Direction
// in      | in_valid, in_stall, mode, operand_*  | consumer of beats
// out     | out_valid, out_stall, result         | producer of beats
// cfg     | cfg_we, cfg_idx, cfg_data            | register writes
//
// One beat a cycle sustained while out is not stalled, through the
// chain of three cells (partial products, product sum, shift/select).
// The chain advances as a whole whenever the last cell is empty or taken;
// a stall on out with out_valid high holds every cell and raises in_stall.
// rst clears valid bits and restores all format registers to 16.
module configurable_fixed_point_alu
  import fxalu_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [IdxW-1:0]         cfg_idx,
  input  logic [CfgW-1:0]         cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              mode,
  input  logic signed [DataW-1:0] operand_a,
  input  logic signed [DataW-1:0] operand_b,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [DataW-1:0] result
);

  logic [CfgW-1:0]    int_bits, frac_bits, tint_bits, tfrac_bits;
  logic               adv;
  ctl_t               c1, c2;
  logic [DataW-1:0]   ll, lh, hl, hh, alt1, alt2, res;
  logic [2*DataW-1:0] prod;

  // Advance the whole row when the output slot is free or being taken.
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      int_bits   <= CfgW'(16);
      frac_bits  <= CfgW'(16);
      tint_bits  <= CfgW'(16);
      tfrac_bits <= CfgW'(16);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_idx))
        REG_INT_BITS:   int_bits   <= cfg_data;
        REG_FRAC_BITS:  frac_bits  <= cfg_data;
        REG_TINT_BITS:  tint_bits  <= cfg_data;
        REG_TFRAC_BITS: tfrac_bits <= cfg_data;
        default: ;
      endcase
    end
  end

  fxalu_front_cell u_front (
    .clk, .rst, .adv,
    .in_vld(in_valid), .in_mode(mode_t'(mode)),
    .a(operand_a), .b(operand_b),
    .int_bits, .frac_bits, .tint_bits, .tfrac_bits,
    .ctl(c1), .pp_ll(ll), .pp_lh(lh), .pp_hl(hl), .pp_hh(hh), .alt(alt1)
  );

  fxalu_sum_cell u_sum (
    .clk, .rst, .adv, .ctl_in(c1),
    .pp_ll(ll), .pp_lh(lh), .pp_hl(hl), .pp_hh(hh), .alt_in(alt1),
    .ctl(c2), .prod, .alt(alt2)
  );

  fxalu_out_cell u_out (
    .clk, .rst, .adv, .ctl_in(c2), .prod, .alt_in(alt2),
    .vld(out_valid), .res
  );

  assign result = res;

`ifndef ASSERT_OFF
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result))
    else $error("result changed under stall");
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    !in_stall && in_valid |=> c1.vld)
    else $error("accepted beat lost in first cell");
`endif

endmodule

/* tb/sv/configurable_fixed_point_alu_test.sv */
module configurable_fixed_point_alu_test;
  import fxalu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 200000;
  localparam int PhaseItems = 150;

  typedef struct {
    logic [1:0]       op;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
  } alu_op_t;

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  logic [IdxW-1:0]         cfg_idx;
  logic [CfgW-1:0]         cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic [1:0]              mode;
  logic signed [DataW-1:0] operand_a;
  logic signed [DataW-1:0] operand_b;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [DataW-1:0] result;

  configurable_fixed_point_alu dut (.*);

  // Shadow copy of the format registers, kept in step with every write.
  logic [CfgW-1:0] fmt_regs [4];

  alu_op_t          pending_ops[$];
  logic [DataW-1:0] expected_results[$];
  int               cycle_count;
  int               mismatches;
  int               ops_sent;
  int               results_seen;
  int               mode_seen [4];
  bit               in_taken;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // ---------------------------------------------------------------------
  // Predictor: fixed-point arithmetic at the block's widths
  // ---------------------------------------------------------------------
  function automatic logic [ShW-1:0] eff_width(logic [CfgW-1:0] ib, logic [CfgW-1:0] fb);
    int s;
    s = int'(ib) + int'(fb);
    if (s > 64) s = 64;
    if (s == 0) s = 1;
    return ShW'(s);
  endfunction

  function automatic logic [DataW-1:0] low_mask(int w);
    logic [DataW-1:0] m;
    if (w >= 64) m = '1;
    else m = (64'd1 << w) - 64'd1;
    return m;
  endfunction

  function automatic logic [DataW-1:0] widen(logic [DataW-1:0] v, int w);
    logic [DataW-1:0] m;
    if (w >= 64) return v;
    m = 64'd1 << (w - 1);
    return ((v & low_mask(w)) ^ m) - m;
  endfunction

  function automatic logic [DataW-1:0] fx_multiply(logic [DataW-1:0] a, logic [DataW-1:0] b);
    int               w;
    int               f;
    logic             na;
    logic             nb;
    logic [DataW-1:0] ma;
    logic [DataW-1:0] mb;
    logic [127:0]     prod;
    logic [DataW-1:0] r;
    w    = int'(eff_width(fmt_regs[REG_INT_BITS], fmt_regs[REG_FRAC_BITS]));
    f    = int'(fmt_regs[REG_FRAC_BITS]);
    na   = a[63];
    nb   = b[63];
    ma   = (na ? -a : a) & low_mask(w);
    mb   = (nb ? -b : b) & low_mask(w);
    prod = {64'd0, ma} * {64'd0, mb};
    prod = prod >> f;
    r    = widen(prod[63:0], w);
    return (na != nb) ? -r : r;
  endfunction

  function automatic logic [DataW-1:0] fx_saturate(logic [DataW-1:0] x);
    logic [DataW-1:0] maxv;
    logic [DataW-1:0] minv;
    maxv = low_mask(int'(eff_width(fmt_regs[REG_INT_BITS], fmt_regs[REG_FRAC_BITS]))) >> 1;
    minv = ~maxv;
    if ($signed(x) > $signed(maxv)) return maxv;
    if ($signed(x) < $signed(minv)) return minv;
    return x;
  endfunction

  function automatic logic [DataW-1:0] fx_convert(logic [DataW-1:0] x);
    int               w;
    int               f;
    int               tw;
    int               tf;
    logic [DataW-1:0] fm;
    logic [DataW-1:0] tfm;
    logic [DataW-1:0] ip;
    logic [DataW-1:0] fp;
    logic [DataW-1:0] packed_v;
    w   = int'(eff_width(fmt_regs[REG_INT_BITS], fmt_regs[REG_FRAC_BITS]));
    f   = int'(fmt_regs[REG_FRAC_BITS]);
    tw  = int'(eff_width(fmt_regs[REG_TINT_BITS], fmt_regs[REG_TFRAC_BITS]));
    tf  = int'(fmt_regs[REG_TFRAC_BITS]);
    fm  = low_mask(f);
    tfm = low_mask(tf);
    ip  = (x & low_mask(w) & ~fm) >> f;
    fp  = x & fm;
    if (tf > f) fp = fp << (tf - f);
    else fp = fp >> (f - tf);
    packed_v = (fp & tfm) | ((ip << tf) & low_mask(tw) & ~tfm);
    return widen(packed_v, tw);
  endfunction

  function automatic logic [DataW-1:0] fx_compute(alu_op_t op);
    case (mode_t'(op.op))
      MODE_MUL:  return fx_multiply(op.a, op.b);
      MODE_SAT:  return fx_saturate(op.a);
      MODE_CONV: return fx_convert(op.a);
      default:   return '0;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Reporting and idle pattern
  // ---------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [DataW-1:0] got, logic [DataW-1:0] want);
    mismatches++;
    $display("MISMATCH cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
  endtask

  // Idle on roughly 38 percent of calls, but never inside the sustained-rate window.
  function automatic bit take_break();
    if (cycle_count >= 1000 && cycle_count < 2000) return 1'b0;
    return $urandom_range(99) < 38;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: advance the input beat at the falling edge once the last one
  // was taken; drop valid only when idling or out of work.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= take_break();
      if (!in_valid || in_taken) begin
        if (pending_ops.size() > 0 && !take_break()) begin
          alu_op_t nxt;
          nxt = pending_ops.pop_front();
          mode      <= nxt.op;
          operand_a <= nxt.a;
          operand_b <= nxt.b;
          in_valid  <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: predict on each accepted input beat, check each output beat.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    alu_op_t          seen;
    logic [DataW-1:0] want;
    cycle_count++;
    in_taken = !rst && in_valid && !in_stall;
    if (in_taken) begin
      seen.op = mode;
      seen.a  = operand_a;
      seen.b  = operand_b;
      expected_results.push_back(fx_compute(seen));
      mode_seen[mode]++;
      ops_sent++;
    end
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", result, '0);
      end else begin
        want = expected_results.pop_front();
        if (result !== want) report_mismatch("result", result, want);
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  function automatic logic [DataW-1:0] pick_operand();
    int               w;
    int               f;
    logic [DataW-1:0] v;
    w = int'(eff_width(fmt_regs[REG_INT_BITS], fmt_regs[REG_FRAC_BITS]));
    f = int'(fmt_regs[REG_FRAC_BITS]);
    v = {$urandom, $urandom};
    case ($urandom_range(5))
      0, 1: v = widen(v, w);
      2: v = widen(v, (w > 2) ? $urandom_range(w, 1) : w);
      3: begin
        case ($urandom_range(5))
          0: v = 64'h8000_0000_0000_0000;
          1: v = 64'h7fff_ffff_ffff_ffff;
          2: v = '0;
          3: v = '1;
          4: v = low_mask(w) >> 1;
          default: v = ~(low_mask(w) >> 1);
        endcase
      end
      4: v = (f < 64) ? ((64'd1 << f) + $signed(64'($urandom_range(7))) - 64'sd3) : v;
      default: ;
    endcase
    if ($urandom_range(9) == 0) v = -v;
    return v;
  endfunction

  task automatic queue_op(logic [1:0] op, logic [DataW-1:0] a, logic [DataW-1:0] b);
    alu_op_t item;
    item.op = op;
    item.a  = a;
    item.b  = b;
    pending_ops.push_back(item);
  endtask

  // Hold until every beat has drained, let the chain empty, then write.
  task automatic write_formats(int ib, int fb, int tib, int tfb);
    int vals [4];
    vals = '{ib, fb, tib, tfb};
    while (pending_ops.size() > 0 || in_valid || expected_results.size() > 0)
      @(negedge clk);
    repeat (6) @(negedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= IdxW'(i);
      cfg_data <= CfgW'(vals[i]);
      fmt_regs[i] = CfgW'(vals[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic queue_random(int n);
    logic [1:0] op;
    for (int i = 0; i < n; i++) begin
      op = ($urandom_range(19) == 0) ? MODE_NONE : 2'($urandom_range(2));
      queue_op(op, pick_operand(), pick_operand());
    end
  endtask

  initial begin
    int ib;
    int fb;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    out_stall = 1'b0;
    mode      = MODE_MUL;
    operand_a = '0;
    operand_b = '0;
    in_taken  = 1'b0;
    cycle_count = 0;
    mismatches  = 0;
    ops_sent    = 0;
    results_seen = 0;
    mode_seen   = '{0, 0, 0, 0};
    fmt_regs    = '{6'd16, 6'd16, 6'd16, 6'd16};
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // Directed beats in the reset format (Q16.16): extremes of each mode,
    // the most negative value negated by multiply, and the unused mode.
    queue_op(MODE_MUL, 64'h0001_0000, 64'h0001_0000);
    queue_op(MODE_MUL, 64'h7fff_ffff, 64'h7fff_ffff);
    queue_op(MODE_MUL, 64'hffff_ffff_8000_0000, 64'h0001_0000);
    queue_op(MODE_MUL, 64'hffff_ffff_8000_0000, 64'hffff_ffff_8000_0000);
    queue_op(MODE_MUL, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff);
    queue_op(MODE_MUL, '1, '1);
    queue_op(MODE_MUL, '0, 64'h7fff_ffff_ffff_ffff);
    queue_op(MODE_MUL, 64'hffff_ffff_ffff_0000, 64'h0000_0000_0002_8000);
    queue_op(MODE_SAT, 64'h7fff_ffff_ffff_ffff, '0);
    queue_op(MODE_SAT, 64'h8000_0000_0000_0000, '0);
    queue_op(MODE_SAT, 64'h0000_0000_7fff_ffff, '0);
    queue_op(MODE_SAT, 64'h0000_0000_8000_0000, '0);
    queue_op(MODE_SAT, 64'hffff_ffff_8000_0000, '0);
    queue_op(MODE_SAT, 64'hffff_ffff_7fff_ffff, '0);
    queue_op(MODE_CONV, 64'h0001_8000, '0);
    queue_op(MODE_CONV, 64'hffff_ffff_8000_0001, '0);
    queue_op(MODE_CONV, 64'h7fff_ffff_ffff_ffff, '0);
    queue_op(MODE_NONE, 64'h1234_5678_9abc_def0, '1);
    queue_op(MODE_NONE, '1, '1);
    queue_random(PhaseItems);

    // Fixed corners: zero-width formats, over-wide formats, pure fraction,
    // pure integer, and widening and narrowing conversions.
    write_formats(0, 0, 0, 0);
    queue_random(PhaseItems / 2);
    write_formats(63, 63, 63, 63);
    queue_random(PhaseItems / 2);
    write_formats(0, 63, 1, 0);
    queue_random(PhaseItems / 2);
    write_formats(63, 0, 0, 62);
    queue_random(PhaseItems / 2);
    write_formats(1, 62, 62, 1);
    queue_random(PhaseItems / 2);
    write_formats(32, 31, 8, 24);
    queue_random(PhaseItems);
    write_formats(12, 20, 40, 23);
    queue_random(PhaseItems);

    // Random formats, kept to legal widths most of the time.
    for (int p = 0; p < 6; p++) begin
      ib = $urandom_range(63);
      fb = (p < 4) ? $urandom_range(63 - ib) : $urandom_range(63);
      write_formats(ib, fb, $urandom_range(63), $urandom_range(63));
      queue_random(PhaseItems);
    end

    while (pending_ops.size() > 0 || in_valid || expected_results.size() > 0)
      @(negedge clk);
    repeat (10) @(negedge clk);

    $display("covered %0d beats (mul %0d, sat %0d, conv %0d, unused %0d), %0d results",
             ops_sent, mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3],
             results_seen);
    $display("format settings: reset, corner widths and random, %0d mismatches", mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
